// ===== rtl/core/wma_pkg.sv =====
// wma_pkg: shared constants and command/status types for the moving average core
// used by wma_ctrl, wma_dpath and windowed_moving_average_core; no dependencies
package wma_pkg;

  // default sizing
  localparam int DEPTH_DEF       = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // window length register
  localparam int LEN_BITS  = 5;
  localparam int LEN_RESET = 4;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture accepted sample and ring slot
    logic rd;        // read the slot being replaced
    logic upd;       // update sum, ring, pointer and count
    logic div_init;  // load divider from sum magnitude
    logic div_step;  // one restoring division step
    logic out_load;  // capture result into output register
  } wma_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;  // current division step is the final one
  } wma_sts_t;

endpackage

// ===== rtl/core/wma_ctrl.sv =====
// wma_ctrl: sequencing state machine and output valid for the moving average core
// depends on wma_pkg
module wma_ctrl import wma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output wma_cmd_t cmd,
  input  wma_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  // result register is never overwritten while a transaction is pending
  a_out_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register loaded while occupied");

  // an accepted transaction always starts the ring read
  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_READ))
    else $error("accept not followed by ring read");

  // final division step leads to result delivery
  a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_DONE))
    else $error("division end not followed by done");

  // a result appears only out of the done state
  a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("output valid rose outside done");
`endif

endmodule

// ===== rtl/core/wma_dpath.sv =====
// wma_dpath: sample ring, running sum, window bookkeeping and serial divider
// depends on wma_pkg; driven by commands from wma_ctrl
module wma_dpath import wma_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [LEN_BITS-1:0]           cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [$clog2(DEPTH+1)-1:0]    out_fill_count,
  input  wma_cmd_t                      cmd,
  output wma_sts_t                      sts
);

  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = SAMPLE_BITS + $clog2(DEPTH);
  localparam int DC_W    = $clog2(SUM_W);
  localparam int CMP_W   = (LEN_BITS > CNT_W) ? LEN_BITS : CNT_W;
  localparam int RST_LEN = (LEN_RESET > DEPTH) ? DEPTH : LEN_RESET;

  logic [CNT_W-1:0]              len_r, len_nxt;
  logic [PTR_W-1:0]              ptr_r, ptr_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;

  logic signed [SAMPLE_BITS-1:0] ring [DEPTH];
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic [PTR_W-1:0]              pos_r;
  logic                          full_r;

  logic [SUM_W-1:0]              quo_r;
  logic [CNT_W-1:0]              rem_r;
  logic                          neg_r;
  logic [DC_W-1:0]               dcnt_r;

  logic [SAMPLE_BITS-1:0]        avg_r;
  logic [CNT_W-1:0]              fill_r;

  logic                          full;
  logic [PTR_W-1:0]              pos;
  logic [CMP_W-1:0]              cfg_ext;
  logic [CNT_W:0]                trial;
  logic                          trial_ge;
  logic [SUM_W-1:0]              quo_signed;

  // slot choice: overwrite oldest when full, else append after held samples
  assign full = (count_r >= len_r);
  assign pos  = full ? ptr_r : count_r[PTR_W-1:0];

  assign cfg_ext = CMP_W'(cfg_data);

  // window bookkeeping and running sum
  always_comb begin
    len_nxt   = len_r;
    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (cfg_we) begin
      if (cfg_ext == '0) begin
        len_nxt = CNT_W'(1);
      end else if (cfg_ext > CMP_W'(DEPTH)) begin
        len_nxt = CNT_W'(DEPTH);
      end else begin
        len_nxt = CNT_W'(cfg_ext);
      end
      ptr_nxt   = '0;
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (cmd.upd) begin
      if (full_r) begin
        sum_nxt = sum_r - SUM_W'(rd_data_r) + SUM_W'(sample_r);
        if (CNT_W'(pos_r) == len_r - 1'b1) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = pos_r + 1'b1;
        end
      end else begin
        sum_nxt   = sum_r + SUM_W'(sample_r);
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= CNT_W'(RST_LEN);
      ptr_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      len_r   <= len_nxt;
      ptr_r   <= ptr_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // accepted sample capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      pos_r    <= pos;
      full_r   <= full;
    end
  end

  // ring memory, one port: read old entry, then write new sample
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      ring[pos_r] <= sample_r;
    end
    if (cmd.rd) begin
      rd_data_r <= ring[pos_r];
    end
  end

  // restoring division of |sum| by count, one quotient bit per cycle
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, count_r});
  assign sts.div_last = (dcnt_r == DC_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r  <= sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
      neg_r  <= sum_r[SUM_W-1];
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SUM_W-2:0], trial_ge};
      rem_r  <= trial_ge ? CNT_W'(trial - {1'b0, count_r}) : trial[CNT_W-1:0];
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // sign restore and output register
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_r  <= quo_signed[SAMPLE_BITS-1:0];
      fill_r <= count_r;
    end
  end

  assign out_average    = signed'(avg_r);
  assign out_fill_count = fill_r;

`ifndef ASSERT_OFF
  // held count never exceeds the window
  a_count_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= len_r)
    else $error("fill count above window length");

  // oldest pointer stays inside the window
  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(ptr_r) < len_r)
    else $error("oldest pointer outside window");

  // pointer only moves once the window is full
  a_ptr_idle_filling: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < len_r) |-> (ptr_r == '0))
    else $error("pointer moved while filling");
`endif

endmodule

// ===== rtl/core/windowed_moving_average_core.sv =====
// windowed_moving_average_core: top level of the sliding window moving average
// depends on wma_pkg, wma_ctrl and wma_dpath
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_sample
//   out      output     out_valid/out_ready  out_average, out_fill_count
//   cfg      input      cfg_we               cfg_data (window length)
//
// each transaction passes accept, ring read, sum update, divider load, the division
// steps and result delivery; the restoring divider produces one quotient bit per cycle
// one sample is in work at a time; a new one is accepted while the last result
// waits in the output register, but a result stalled by out_ready holds the divider
// synchronous active-low reset: window length 4, ring empty, no result pending
module windowed_moving_average_core import wma_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [$clog2(DEPTH+1)-1:0]    out_fill_count,
  input  logic                          cfg_we,
  input  logic [LEN_BITS-1:0]           cfg_data
);

  wma_cmd_t cmd;
  wma_sts_t sts;

  // sequencing
  wma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and arithmetic
  wma_dpath #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_sample      (in_sample),
    .out_average    (out_average),
    .out_fill_count (out_fill_count),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== tb/moving_average_checker.sv =====
`timescale 1ns / 1ps
// moving_average_checker: watches the sample, result and window length ports of the
// moving average core, predicts every mean and compares it; depends on wma_pkg
module moving_average_checker import wma_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [SAMPLE_BITS_DEF-1:0] in_sample,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [SAMPLE_BITS_DEF-1:0] out_average,
  input  logic [$clog2(DEPTH_DEF+1)-1:0]    out_fill_count,
  input  logic                              cfg_we,
  input  logic [LEN_BITS-1:0]               cfg_data,
  output int                                mismatch_count,
  output int                                results_pending
);

  localparam int RING_DEPTH   = DEPTH_DEF;
  localparam int FILL_W       = $clog2(DEPTH_DEF + 1);
  localparam int EXPECT_DEPTH = 16;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] average;
    logic [FILL_W-1:0]                 fill_count;
  } mean_result_t;

  // predicted means, oldest at the read slot
  mean_result_t expected_means[EXPECT_DEPTH];
  int exp_rd_slot;
  int exp_wr_slot;
  int exp_used;

  // private copy of the window state
  logic signed [SAMPLE_BITS_DEF-1:0] ring[RING_DEPTH];
  int oldest_slot;
  int held_samples;
  int window_sum;
  int window_len;

  // zero means one, anything past the ring depth saturates
  function automatic int clamp_window(input logic [LEN_BITS-1:0] value);
    if (value == 0) return 1;
    if (value > RING_DEPTH) return RING_DEPTH;
    return int'(value);
  endfunction

  // slide one sample into the window and return the resulting mean
  function automatic mean_result_t next_mean(input logic signed [SAMPLE_BITS_DEF-1:0] s);
    mean_result_t r;
    int pos;
    if (held_samples >= window_len) begin
      // full window: replace the oldest sample
      pos = oldest_slot % window_len;
      window_sum = window_sum - ring[pos] + s;
      ring[pos] = s;
      oldest_slot = (pos + 1) % window_len;
    end else begin
      pos = (oldest_slot + held_samples) % window_len;
      ring[pos] = s;
      window_sum = window_sum + s;
      held_samples++;
    end
    // int division truncates toward zero
    r.average = SAMPLE_BITS_DEF'(window_sum / held_samples);
    r.fill_count = FILL_W'(held_samples);
    return r;
  endfunction

  // result check, window length writes and sample prediction
  always @(posedge clk) begin
    mean_result_t got;
    mean_result_t want;
    if (!rst_n) begin
      window_len = LEN_RESET;
      oldest_slot = 0;
      held_samples = 0;
      window_sum = 0;
      mismatch_count = 0;
      exp_rd_slot = 0;
      exp_wr_slot = 0;
      exp_used = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.average = out_average;
        got.fill_count = out_fill_count;
        if (exp_used == 0) begin
          mismatch_count++;
          $display("%0t: result transaction with nothing expected: average %0d fill %0d",
                   $time, got.average, got.fill_count);
        end else begin
          want = expected_means[exp_rd_slot];
          exp_rd_slot = (exp_rd_slot + 1) % EXPECT_DEPTH;
          exp_used--;
          if (got.average !== want.average) begin
            mismatch_count++;
            $display("%0t: average mismatch: expected %0d actual %0d",
                     $time, want.average, got.average);
          end
          if (got.fill_count !== want.fill_count) begin
            mismatch_count++;
            $display("%0t: fill count mismatch: expected %0d actual %0d",
                     $time, want.fill_count, got.fill_count);
          end
        end
      end
      if (cfg_we) begin
        window_len = clamp_window(cfg_data);
        oldest_slot = 0;
        held_samples = 0;
        window_sum = 0;
      end
      if (in_valid && in_ready) begin
        if (exp_used == EXPECT_DEPTH) begin
          mismatch_count++;
          $display("%0t: too many sample transactions outstanding: expected at most %0d",
                   $time, EXPECT_DEPTH);
        end else begin
          expected_means[exp_wr_slot] = next_mean(in_sample);
          exp_wr_slot = (exp_wr_slot + 1) % EXPECT_DEPTH;
          exp_used++;
        end
      end
    end
    results_pending = exp_used;
  end

endmodule

// ===== tb/tb_windowed_moving_average_core.sv =====
`timescale 1ns / 1ps
// tb_windowed_moving_average_core: clock, reset, sample and window length stimulus
// depends on wma_pkg, windowed_moving_average_core and moving_average_checker
module tb_windowed_moving_average_core;
  import wma_pkg::*;

  localparam int SW           = SAMPLE_BITS_DEF;
  localparam int FILL_W       = $clog2(DEPTH_DEF + 1);
  localparam int RANDOM_ITEMS = 678;
  localparam int PHASE_COUNT  = 3;
  localparam int MAX_SEGMENT  = 40;
  localparam int LONG_STALL   = 200;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [LEN_BITS-1:0] WIN_ZERO = '0;
  localparam logic [LEN_BITS-1:0] WIN_ONE  = LEN_BITS'(1);
  localparam logic [LEN_BITS-1:0] WIN_FULL = LEN_BITS'(DEPTH_DEF);
  localparam logic [LEN_BITS-1:0] WIN_OVER = LEN_BITS'(DEPTH_DEF + 1);
  localparam logic [LEN_BITS-1:0] WIN_MAX  = '1;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SAMPLE_NEG_ONE = '1;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [SW-1:0]    in_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SW-1:0]    out_average;
  logic [FILL_W-1:0]       out_fill_count;
  logic                    cfg_we    = 1'b0;
  logic [LEN_BITS-1:0]     cfg_data  = '0;

  int mismatch_count;
  int results_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;
  int samples_sent = 0;
  int windows_written = 0;
  int cycle_count = 0;

  windowed_moving_average_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_average   (out_average),
    .out_fill_count(out_fill_count),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  moving_average_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_fill_count (out_fill_count),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, results_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side ready, with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (stall_requests != stall_served) begin
      stall_served++;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one sample transaction and wait until it is taken; called at a falling edge
  task automatic send_sample(input logic signed [SW-1:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    samples_sent++;
  endtask

  // write the window length once every mean has come back
  task automatic write_window(input logic [LEN_BITS-1:0] len);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    windows_written++;
  endtask

  // extremes, small values around zero and full-range values
  function automatic logic signed [SW-1:0] random_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3, 4: return SW'($signed($urandom_range(511)) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  // window lengths with the extremes and the out-of-range writes favored
  function automatic logic [LEN_BITS-1:0] random_window();
    case ($urandom_range(6))
      0:       return WIN_ZERO;
      1:       return WIN_ONE;
      2:       return WIN_FULL;
      3:       return WIN_OVER;
      4:       return WIN_MAX;
      default: return LEN_BITS'($urandom_range(31));
    endcase
  endfunction

  initial begin
    int left;
    int seg;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset window of four: extremes, then one eviction
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_NEG_ONE);
    send_sample(SAMPLE_MAX);

    // zero length acts as a window of one
    write_window(WIN_ZERO);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);

    // oversized length saturates to the full ring; sum reaches its negative limit
    write_window(WIN_MAX);
    repeat (DEPTH_DEF + 1) send_sample(SAMPLE_MIN);

    // random segments, each under a fresh window length
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin send_idle_pct = 38; recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      left = RANDOM_ITEMS / PHASE_COUNT;
      while (left > 0) begin
        write_window(random_window());
        seg = $urandom_range(1, MAX_SEGMENT);
        while (seg > 0 && left > 0) begin
          // back-pressure the output mid-phase while samples keep coming
          if (phase == PHASE_COUNT - 1 && left == RANDOM_ITEMS / (2 * PHASE_COUNT))
            stall_requests++;
          send_sample(random_sample());
          seg--;
          left--;
        end
      end
    end

    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d samples over %0d window length writes,", samples_sent,
             windows_written);
    $display("with sender and receiver gaps and a %0d cycle output hold-off", LONG_STALL);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
